[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  `ASSERT_CLK(label, clk, rst, !(expr), msg)

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[src/pdwrd_pkg.sv]
// ----------------------------------------------------------------------------
// pdwrd_pkg
// types and constants of the packet delay window retransmission detector
// ----------------------------------------------------------------------------
package pdwrd_pkg;

  localparam int TIME_W   = 64;
  localparam int DELAY_W  = 32;
  localparam int WORD_W   = TIME_W + DELAY_W;
  localparam int DIFF_W   = 23;
  localparam int CNT_OUT_W = 6;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_US_W = 26;

  // x / 1000 == (x * RECIP_MUL) >> RECIP_SHIFT for every 32-bit x
  localparam int RECIP_W = 29;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd274877907;
  localparam int RECIP_SHIFT = 38;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SCAN   = 1'b1;

  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_ENTRY    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

  localparam logic [REG_W-1:0] WINDOW_RESET    = 16'd1000;
  localparam logic [REG_W-1:0] THRESHOLD_RESET = 16'd10;
  localparam logic [WIN_US_W-1:0] WIN_US_RESET = 26'd1000000;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHK      = 10'b00_0000_0010,
    S_EVICT    = 10'b00_0000_0100,
    S_APPEND   = 10'b00_0000_1000,
    S_ONE      = 10'b00_0001_0000,
    S_SCAN_RD  = 10'b00_0010_0000,
    S_SCAN_SUB = 10'b00_0100_0000,
    S_SCAN_NEG = 10'b00_1000_0000,
    S_SCAN_MUL = 10'b01_0000_0000,
    S_SCAN_OUT = 10'b10_0000_0000
  } state_t;

endpackage

[src/packet_delay_window_retx_detector.sv]
// ----------------------------------------------------------------------------
// packet_delay_window_retx_detector
// time-ordered window of received packets with delay-change based
// retransmission detection
// ----------------------------------------------------------------------------
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  tuser: command; tdata: recv time, delay
// m_*      out  m_tvalid / m_tready  tuser: status; tdata: entry report;
//                                    tlast: final result of the command
// cfg_*    in   cfg_we               cfg_index, cfg_data
//
// insert: an empty window goes straight to the append; otherwise the new
//   time is checked against the newest entry (an earlier time is rejected),
//   aged entries are evicted from the front one at a time, then it appends;
//   the window walk shares one 64-bit subtractor
// scan: each stored entry is read, subtracted, multiplied and reported; when
//   the delay falls, the abs value goes through the same subtractor twice;
//   one ram read per entry; a scan of an empty window reports empty status
// a result waits in the output register; the next result stalls while it is held
// rst is synchronous: the window empties and the registers return to
//   window 1000 ms, threshold 10 ms; ram contents are not cleared
//
`include "assert_macros.svh"

module packet_delay_window_retx_detector #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [95:0]                      s_tdata,  // recv_time_us, oneway_delay_us
  input  logic [0:0]                       s_tuser,  // command
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_recv_time_us, out_oneway_us, delay_change_ms, is_retx, retx_count,
  // stored_count, zero pad
  output logic [135:0]                     m_tdata,
  output logic [1:0]                       m_tuser,  // status
  output logic                             m_tlast,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [pdwrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdwrd_pkg::REG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int PROD_W = pdwrd_pkg::DELAY_W + pdwrd_pkg::RECIP_W;

  // configuration
  logic [pdwrd_pkg::REG_W-1:0]    window_ms;
  logic [pdwrd_pkg::REG_W-1:0]    retx_threshold_ms;
  logic [pdwrd_pkg::WIN_US_W-1:0] win_us;

  // control
  pdwrd_pkg::state_t state;
  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [AW-1:0] k;
  logic [CW-1:0] cnt;
  logic [1:0]    one_status;

  // latched input transfer
  logic [pdwrd_pkg::TIME_W-1:0]  t_r;
  logic [pdwrd_pkg::DELAY_W-1:0] d_r;

  // scan datapath
  logic [pdwrd_pkg::TIME_W-1:0]  e_time;
  logic [pdwrd_pkg::DELAY_W-1:0] e_delay;
  logic [pdwrd_pkg::DELAY_W-1:0] prev;
  logic [pdwrd_pkg::DELAY_W-1:0] absd;
  logic [PROD_W-1:0]             prod;

  // output register
  logic [1:0]                      o_status;
  logic [pdwrd_pkg::TIME_W-1:0]    o_time;
  logic [pdwrd_pkg::DELAY_W-1:0]   o_delay;
  logic [pdwrd_pkg::DIFF_W-1:0]    o_diff;
  logic                            o_retx;
  logic [pdwrd_pkg::CNT_OUT_W-1:0] o_rc;
  logic [pdwrd_pkg::CNT_OUT_W-1:0] o_sc;

  // ram
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [pdwrd_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [pdwrd_pkg::WORD_W-1:0]  ram_rdata;
  logic [pdwrd_pkg::TIME_W-1:0]  rd_time;
  logic [pdwrd_pkg::DELAY_W-1:0] rd_delay;

  // shared subtractor
  logic [pdwrd_pkg::TIME_W-1:0] unit_a;
  logic [pdwrd_pkg::TIME_W-1:0] unit_b;
  logic [pdwrd_pkg::TIME_W-1:0] unit_diff;
  logic                         unit_borrow;

  logic                         in_xfer;
  logic                         out_free;
  logic                         out_load;
  logic                         evict;
  logic [AW-1:0]                front_inc;
  logic                         full;
  logic                         scan_last;
  logic [pdwrd_pkg::DIFF_W-1:0] q;
  logic                         retx;
  logic [CW-1:0]                cnt_next;

  // ring index: base + offset, both below the depth
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(WINDOW_DEPTH)) begin
      sum = sum - (AW+1)'(WINDOW_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign s_tready = (state == pdwrd_pkg::S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // a result moves into the output register this cycle
  assign out_load = out_free &&
                    ((state == pdwrd_pkg::S_ONE) || (state == pdwrd_pkg::S_SCAN_OUT));

  assign rd_time  = ram_rdata[pdwrd_pkg::TIME_W-1:0];
  assign rd_delay = ram_rdata[pdwrd_pkg::WORD_W-1:pdwrd_pkg::TIME_W];

  assign front_inc = (front == AW'(WINDOW_DEPTH - 1)) ? '0 : front + AW'(1);
  assign full      = (count == CW'(WINDOW_DEPTH));
  assign scan_last = ((CW'(k) + CW'(1)) == count);

  // divide by 1000 through the registered reciprocal product
  assign q        = prod[pdwrd_pkg::RECIP_SHIFT +: pdwrd_pkg::DIFF_W];
  assign retx     = (q >= pdwrd_pkg::DIFF_W'(retx_threshold_ms));
  assign cnt_next = cnt + CW'(retx);

  // operand select for the one subtractor
  always_comb begin
    case (state)
      pdwrd_pkg::S_CHK, pdwrd_pkg::S_EVICT: begin
        unit_a = t_r;
        unit_b = rd_time;
      end
      pdwrd_pkg::S_SCAN_SUB: begin
        unit_a = pdwrd_pkg::TIME_W'(rd_delay);
        unit_b = pdwrd_pkg::TIME_W'(prev);
      end
      pdwrd_pkg::S_SCAN_NEG: begin
        unit_a = pdwrd_pkg::TIME_W'(prev);
        unit_b = pdwrd_pkg::TIME_W'(e_delay);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign {unit_borrow, unit_diff} = {1'b0, unit_a} - {1'b0, unit_b};

  // stored times are ordered, so the new time never borrows against them
  assign evict = (unit_diff > pdwrd_pkg::TIME_W'(win_us));

  // ram read address follows the walk: newest, front, next front, scan slot
  always_comb begin
    case (state)
      pdwrd_pkg::S_IDLE:    ram_raddr = slot_add(front, AW'(count - CW'(1)));
      pdwrd_pkg::S_CHK:     ram_raddr = front;
      pdwrd_pkg::S_EVICT:   ram_raddr = evict ? front_inc : front;
      pdwrd_pkg::S_SCAN_RD: ram_raddr = slot_add(front, k);
      default:              ram_raddr = front;
    endcase
  end

  // append writes the free slot, or the oldest slot when the window is full
  assign ram_we    = (state == pdwrd_pkg::S_APPEND);
  assign ram_waddr = full ? front : slot_add(front, AW'(count));
  assign ram_wdata = {d_r, t_r};

  pdwrd_ram #(
    .WIDTH (pdwrd_pkg::WORD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers and the window in microseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms         <= pdwrd_pkg::WINDOW_RESET;
      retx_threshold_ms <= pdwrd_pkg::THRESHOLD_RESET;
      win_us            <= pdwrd_pkg::WIN_US_RESET;
    end else begin
      if (cfg_we && (cfg_index == pdwrd_pkg::REG_WINDOW)) begin
        window_ms <= cfg_data;
      end
      if (cfg_we && (cfg_index == pdwrd_pkg::REG_THRESHOLD)) begin
        retx_threshold_ms <= cfg_data;
      end
      win_us <= pdwrd_pkg::WIN_US_W'(window_ms) *
                pdwrd_pkg::WIN_US_W'(pdwrd_pkg::US_PER_MS);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pdwrd_pkg::S_IDLE;
      front    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pdwrd_pkg::S_IDLE: begin
          if (in_xfer) begin
            if (s_tuser[0] == pdwrd_pkg::CMD_INSERT) begin
              state <= (count == '0) ? pdwrd_pkg::S_APPEND : pdwrd_pkg::S_CHK;
            end else if (count == '0) begin
              one_status <= pdwrd_pkg::STATUS_EMPTY;
              state      <= pdwrd_pkg::S_ONE;
            end else begin
              k     <= '0;
              cnt   <= '0;
              state <= pdwrd_pkg::S_SCAN_RD;
            end
          end
        end
        pdwrd_pkg::S_CHK: begin
          // strictly earlier than the newest entry is out of order
          if (unit_borrow) begin
            one_status <= pdwrd_pkg::STATUS_REJECTED;
            state      <= pdwrd_pkg::S_ONE;
          end else begin
            state <= pdwrd_pkg::S_EVICT;
          end
        end
        pdwrd_pkg::S_EVICT: begin
          if (evict) begin
            front <= front_inc;
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state <= pdwrd_pkg::S_APPEND;
            end
          end else begin
            state <= pdwrd_pkg::S_APPEND;
          end
        end
        pdwrd_pkg::S_APPEND: begin
          if (full) begin
            front <= front_inc;
          end else begin
            count <= count + CW'(1);
          end
          one_status <= pdwrd_pkg::STATUS_INSERTED;
          state      <= pdwrd_pkg::S_ONE;
        end
        pdwrd_pkg::S_ONE: begin
          if (out_free) begin
            o_status <= one_status;
            o_time   <= (one_status == pdwrd_pkg::STATUS_EMPTY) ? '0 : t_r;
            o_delay  <= (one_status == pdwrd_pkg::STATUS_EMPTY) ? '0 : d_r;
            o_diff   <= '0;
            o_retx   <= 1'b0;
            o_rc     <= '0;
            o_sc     <= pdwrd_pkg::CNT_OUT_W'(count);
            m_tlast  <= 1'b1;
            state    <= pdwrd_pkg::S_IDLE;
          end
        end
        pdwrd_pkg::S_SCAN_RD: begin
          state <= pdwrd_pkg::S_SCAN_SUB;
        end
        pdwrd_pkg::S_SCAN_SUB: begin
          e_time  <= rd_time;
          e_delay <= rd_delay;
          // first entry has no previous delay
          if (k == '0) begin
            absd  <= '0;
            state <= pdwrd_pkg::S_SCAN_MUL;
          end else if (unit_borrow) begin
            state <= pdwrd_pkg::S_SCAN_NEG;
          end else begin
            absd  <= unit_diff[pdwrd_pkg::DELAY_W-1:0];
            state <= pdwrd_pkg::S_SCAN_MUL;
          end
        end
        pdwrd_pkg::S_SCAN_NEG: begin
          absd  <= unit_diff[pdwrd_pkg::DELAY_W-1:0];
          state <= pdwrd_pkg::S_SCAN_MUL;
        end
        pdwrd_pkg::S_SCAN_MUL: begin
          prod  <= PROD_W'(absd) * PROD_W'(pdwrd_pkg::RECIP_MUL);
          state <= pdwrd_pkg::S_SCAN_OUT;
        end
        pdwrd_pkg::S_SCAN_OUT: begin
          if (out_free) begin
            o_status <= pdwrd_pkg::STATUS_ENTRY;
            o_time   <= e_time;
            o_delay  <= e_delay;
            o_diff   <= q;
            o_retx   <= retx;
            o_rc     <= pdwrd_pkg::CNT_OUT_W'(cnt_next);
            o_sc     <= pdwrd_pkg::CNT_OUT_W'(count);
            m_tlast  <= scan_last;
            prev     <= e_delay;
            cnt      <= cnt_next;
            if (scan_last) begin
              state <= pdwrd_pkg::S_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= pdwrd_pkg::S_SCAN_RD;
            end
          end
        end
        default: begin
          state <= pdwrd_pkg::S_IDLE;
        end
      endcase
      if (in_xfer) begin
        t_r <= s_tdata[pdwrd_pkg::TIME_W-1:0];
        d_r <= s_tdata[pdwrd_pkg::WORD_W-1:pdwrd_pkg::TIME_W];
      end
    end
  end

  assign m_tuser = o_status;
  assign m_tdata = {4'b0000, o_sc, o_rc, o_retx, o_diff, o_delay, o_time};

  // the fill count only moves while an insert walks the window
  `ASSERT_CLK(a_idle_count_hold, clk, rst, (state == pdwrd_pkg::S_IDLE) |=> (count == $past(count)), "count changed while idle")
  // eviction never runs on an empty window
  `ASSERT_NEVER(a_evict_nonempty, clk, rst, (state == pdwrd_pkg::S_EVICT) && (count == '0), "eviction on empty window")
  // an append always leaves at least one entry
  `ASSERT_CLK(a_append_fills, clk, rst, (state == pdwrd_pkg::S_APPEND) |=> (count != '0), "append left window empty")
  // retransmissions seen so far never outnumber the entries already reported
  `ASSERT_NEVER(a_retx_bound, clk, rst, (state == pdwrd_pkg::S_SCAN_OUT) && (cnt > CW'(k)), "retx count above entries")

endmodule

[src/pdwrd_ram.sv]
// ----------------------------------------------------------------------------
// pdwrd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pdwrd_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the packet delay window retransmission detector:
// directed opening rows, random phases and directed closing rows drive the input
// stream, a queue-based window predictor computes every expected result,
// and each result transfer is checked field by field against it
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 32;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 16;   // block finishing work after its last result
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int OPEN_ROWS       = 23;
  localparam int CLOSE_ROWS      = 4;
  localparam logic [63:0] MS_US  = 64'd1000;
  localparam logic [63:0] T_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

  // codes taken from the package
  localparam logic CMD_INSERT = pdwrd_pkg::CMD_INSERT;
  localparam logic CMD_SCAN   = pdwrd_pkg::CMD_SCAN;
  localparam logic [1:0] STATUS_INSERTED = pdwrd_pkg::STATUS_INSERTED;
  localparam logic [1:0] STATUS_REJECTED = pdwrd_pkg::STATUS_REJECTED;
  localparam logic [1:0] STATUS_ENTRY    = pdwrd_pkg::STATUS_ENTRY;
  localparam logic [1:0] STATUS_EMPTY    = pdwrd_pkg::STATUS_EMPTY;
  localparam logic [pdwrd_pkg::CFG_IDX_W-1:0] REG_WINDOW    = pdwrd_pkg::REG_WINDOW;
  localparam logic [pdwrd_pkg::CFG_IDX_W-1:0] REG_THRESHOLD = pdwrd_pkg::REG_THRESHOLD;

  // indexes past the register list, writes there must be ignored
  localparam logic [pdwrd_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [pdwrd_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] rtime;
    logic [31:0] delay;
    logic [22:0] diff;
    logic        retx;
    logic [5:0]  retx_cnt;
    logic [5:0]  stored;
    logic        is_last;
  } report_t;

  typedef enum logic [1:0] {ROW_INSERT, ROW_SCAN, ROW_FILL, ROW_CFG} row_kind_t;

  // one directed step; for ROW_CFG arg_t is the register index and arg_d the data,
  // for ROW_FILL rep inserts are made 1 ms apart
  typedef struct {
    row_kind_t   kind;
    logic [63:0] arg_t;
    logic [31:0] arg_d;
    int          rep;
    logic        typed;
    logic [1:0]  want_status;
    logic [5:0]  want_stored;
  } row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;   // recv_time_us, oneway_delay_us
  logic [0:0]   s_tuser;   // command
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;   // out_recv_time_us, out_oneway_us, delay_change_ms, is_retx,
                           // retx_count, stored_count, zero pad
  logic [1:0]   m_tuser;   // status
  logic         m_tlast;
  logic         cfg_we;
  logic [pdwrd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pdwrd_pkg::REG_W-1:0]     cfg_data;

  // predictor state: the window as two parallel queues, oldest first
  logic [63:0] win_times[$];
  logic [31:0] win_delays[$];
  logic [15:0] win_ms = pdwrd_pkg::WINDOW_RESET;
  logic [15:0] thr_ms = pdwrd_pkg::THRESHOLD_RESET;

  report_t pending_reports[$];
  int      mismatches = 0;
  int      burst_left = 0;
  logic    hold_off_req = 1'b0;
  logic    hold_off_done = 1'b0;

  row_t opening_rows [OPEN_ROWS] = '{
    // empty window scan, then equal receive times accepted
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b1, STATUS_EMPTY,    6'd0},
    '{ROW_INSERT, 64'd0,         32'd0,          0,  1'b1, STATUS_INSERTED, 6'd1},
    '{ROW_INSERT, 64'd0,         32'hFFFF_FFFF,  0,  1'b1, STATUS_INSERTED, 6'd2},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0},
    '{ROW_INSERT, 64'd1000,      32'd20000,      0,  1'b1, STATUS_INSERTED, 6'd3},
    // earlier than the newest entry: rejected, window untouched
    '{ROW_INSERT, 64'd999,       32'd7,          0,  1'b1, STATUS_REJECTED, 6'd3},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0},
    // whole window expired, then age exactly at the limit is kept
    '{ROW_INSERT, 64'd2000000,   32'd5000,       0,  1'b1, STATUS_INSERTED, 6'd1},
    '{ROW_INSERT, 64'd3000000,   32'd16000,      0,  1'b1, STATUS_INSERTED, 6'd2},
    '{ROW_INSERT, 64'd3000001,   32'd16000,      0,  1'b1, STATUS_INSERTED, 6'd2},
    // overfill: the oldest entries get dropped
    '{ROW_FILL,   64'd3100000,   32'd1000,       33, 1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0},
    // threshold zero: every entry counts, the first one too
    '{ROW_CFG,    64'(REG_THRESHOLD), 32'd0,     0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0},
    // window zero: only strictly older entries leave
    '{ROW_CFG,    64'(REG_WINDOW), 32'd0,        0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_INSERT, 64'd3132000,   32'd0,          0,  1'b1, STATUS_INSERTED, 6'd2},
    '{ROW_CFG,    64'(REG_SPARE2), 32'hFFFF,     0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_CFG,    64'(REG_SPARE3), 32'hFFFF,     0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0},
    // register maximums
    '{ROW_CFG,    64'(REG_WINDOW), 32'hFFFF,     0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_CFG,    64'(REG_THRESHOLD), 32'hFFFF,  0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_INSERT, 64'd3132000,   32'hFFFF_FFFF,  0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0}
  };

  // run ends on the largest receive time: every stored entry is far too old
  row_t closing_rows [CLOSE_ROWS] = '{
    '{ROW_INSERT, T_MAX,         32'h8000_0001,  0,  1'b1, STATUS_INSERTED, 6'd1},
    '{ROW_INSERT, 64'd0,         32'hFFFF,       0,  1'b1, STATUS_REJECTED, 6'd1},
    '{ROW_INSERT, T_MAX,         32'd0,          0,  1'b0, STATUS_INSERTED, 6'd0},
    '{ROW_SCAN,   64'd0,         32'd0,          0,  1'b0, STATUS_ENTRY,    6'd0}
  };

  logic [15:0] phase_window [PHASES] = '{16'd1000, 16'd1, 16'd50, 16'd0, 16'd65535, 16'd200};
  logic [15:0] phase_thr    [PHASES] = '{16'd10, 16'd1, 16'd0, 16'd5, 16'd65535, 16'd2};

  packet_delay_window_retx_detector #(
    .WINDOW_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // window predictor: works out the results of one accepted transfer
  // and appends them to pending_reports
  function automatic void predict_reports(input logic cmd, input logic [63:0] t,
                                          input logic [31:0] d);
    report_t     r;
    logic [63:0] win_us;
    logic [31:0] prev;
    logic [31:0] mag;
    logic [5:0]  cnt;
    r = '0;
    r.is_last = 1'b1;
    if (cmd == CMD_INSERT) begin
      r.rtime = t;
      r.delay = d;
      // strictly earlier than the newest entry: refused, nothing changes
      if (win_times.size() > 0 && t < win_times[$]) begin
        r.status = STATUS_REJECTED;
        r.stored = 6'(win_times.size());
        pending_reports.push_back(r);
        return;
      end
      win_us = 64'(win_ms) * MS_US;
      while (win_times.size() > 0 && t - win_times[0] > win_us) begin
        void'(win_times.pop_front());
        void'(win_delays.pop_front());
      end
      // still full after aging out: drop the oldest
      if (win_times.size() >= DEPTH) begin
        void'(win_times.pop_front());
        void'(win_delays.pop_front());
      end
      win_times.push_back(t);
      win_delays.push_back(d);
      r.status = STATUS_INSERTED;
      r.stored = 6'(win_times.size());
      pending_reports.push_back(r);
    end else if (win_times.size() == 0) begin
      r.status = STATUS_EMPTY;
      pending_reports.push_back(r);
    end else begin
      cnt  = '0;
      prev = win_delays[0];
      foreach (win_times[k]) begin
        r = '0;
        r.status = STATUS_ENTRY;
        r.rtime  = win_times[k];
        r.delay  = win_delays[k];
        mag      = (win_delays[k] >= prev) ? win_delays[k] - prev : prev - win_delays[k];
        // first entry has no predecessor, so its change is zero
        r.diff   = (k == 0) ? 23'd0 : 23'(mag / 32'd1000);
        r.retx   = (32'(r.diff) >= 32'(thr_ms));
        cnt      = cnt + 6'(r.retx);
        r.retx_cnt = cnt;
        r.stored = 6'(win_times.size());
        r.is_last = (k == win_times.size() - 1);
        pending_reports.push_back(r);
        prev = win_delays[k];
      end
    end
  endfunction

  // one input transfer; the sender runs in bursts with random gaps between them.
  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic cmd, input logic [63:0] t, input logic [31:0] d,
                           input logic typed, input report_t want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {d, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_reports(cmd, t, d);
    // a typed-in expectation stands in for the predicted one
    if (typed) begin
      void'(pending_reports.pop_back());
      pending_reports.push_back(want);
    end
    @(negedge clk);
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input logic [pdwrd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdwrd_pkg::REG_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW) begin
      win_ms = val;
    end else if (idx == REG_THRESHOLD) begin
      thr_ms = val;
    end
  endtask

  task automatic run_row(input row_t r);
    report_t want;
    want = '0;
    case (r.kind)
      ROW_CFG: begin
        write_reg(r.arg_t[pdwrd_pkg::CFG_IDX_W-1:0], r.arg_d[pdwrd_pkg::REG_W-1:0]);
      end
      ROW_FILL: begin
        // 1 ms apart, delay creeping up with a 15 ms swing on odd entries
        for (int k = 0; k < r.rep; k++) begin
          send_item(CMD_INSERT, r.arg_t + 64'(k) * MS_US,
                    r.arg_d + 32'(k * 500) + ((k % 2 == 1) ? 32'd15000 : 32'd0),
                    1'b0, want);
        end
      end
      default: begin
        want.status  = r.want_status;
        want.stored  = r.want_stored;
        want.is_last = 1'b1;
        if (r.kind == ROW_INSERT) begin
          want.rtime = r.arg_t;
          want.delay = r.arg_d;
        end
        send_item((r.kind == ROW_SCAN) ? CMD_SCAN : CMD_INSERT, r.arg_t, r.arg_d,
                  r.typed, want);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: compare every accepted transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    report_t got;
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status   = m_tuser;
      got.rtime    = m_tdata[63:0];
      got.delay    = m_tdata[95:64];
      got.diff     = m_tdata[118:96];
      got.retx     = m_tdata[119];
      got.retx_cnt = m_tdata[125:120];
      got.stored   = m_tdata[131:126];
      got.is_last  = m_tlast;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d time %0h",
                 $time, got.status, got.rtime);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("recv_time", want.rtime, got.rtime);
        check_field("oneway_delay", 64'(want.delay), 64'(got.delay));
        check_field("delay_change_ms", 64'(want.diff), 64'(got.diff));
        check_field("is_retx", 64'(want.retx), 64'(got.retx));
        check_field("retx_count", 64'(want.retx_cnt), 64'(got.retx_cnt));
        check_field("stored_count", 64'(want.stored), 64'(got.stored));
        check_field("last", 64'(want.is_last), 64'(got.is_last));
      end
    end
  end

  // receiver: stall patterns of random length, plus one long hold-off
  // while the sender keeps offering so the block backs up
  initial begin : receiver
    int mode;
    int span;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        if (hold_off_req && !hold_off_done) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_done = 1'b1;
        end else begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (i % 4 == 3);
            default: m_tready <= i[0];
          endcase
        end
      end
    end
  end

  // run time limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] cur_time;
    logic [63:0] win_us;
    logic [63:0] step_max;
    logic [63:0] t;
    logic [31:0] base_delay;
    logic [31:0] spread;
    logic [31:0] d;
    report_t     none;
    int          roll;
    int          jumps;
    none      = '0;
    jumps     = 0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_rows[i]) run_row(opening_rows[i]);

    base_delay = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_WINDOW, phase_window[p]);
      write_reg(REG_THRESHOLD, phase_thr[p]);
      write_reg((p % 2 == 0) ? REG_SPARE2 : REG_SPARE3, 16'($urandom));
      if (p == 1) hold_off_req = 1'b1;
      win_us   = 64'(phase_window[p]) * MS_US;
      step_max = win_us / 64'($urandom_range(3, 40)) + 64'd1;
      spread   = 32'(phase_thr[p]) * 32'd2000 + 32'd3000;
      cur_time = win_times[$];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
          // scan, payload is don't-care
          send_item(CMD_SCAN, {$urandom, $urandom}, $urandom, 1'b0, none);
        end else if (roll < 20) begin
          // out-of-order arrival
          t = {$urandom, $urandom};
          if (cur_time != 0) t = t % cur_time;
          send_item(CMD_INSERT, t, $urandom, 1'b0, none);
        end else begin
          if (roll < 22) begin
            // long silence: everything stored ages out
            cur_time = cur_time + win_us + 64'd1 + 64'($urandom_range(0, 1000));
          end else if (roll < 24 && jumps < 12) begin
            // big step to move the high timestamp bits
            cur_time = cur_time + (64'd1 << $urandom_range(20, 58));
            jumps++;
          end else if (roll >= 30) begin
            cur_time = cur_time + 64'($urandom_range(0, 32'(step_max)));
          end
          if ($urandom_range(0, 19) == 0) base_delay = $urandom;
          d = base_delay + $urandom_range(0, 2 * spread) - spread;
          send_item(CMD_INSERT, cur_time, d, 1'b0, none);
        end
      end
    end

    foreach (closing_rows[i]) run_row(closing_rows[i]);

    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pdwrd_pkg.sv
src/pdwrd_ram.sv
src/packet_delay_window_retx_detector.sv
tb/testbench.sv
